// ===== rtl/cpet_pkg.sv =====
package cpet_pkg;
	localparam int MAX_COLLIDERS = 64;
	localparam int ID_W = $clog2(MAX_COLLIDERS);
	localparam int IDX_W = 2 * ID_W;
	localparam int PAIRS = MAX_COLLIDERS * MAX_COLLIDERS;
	localparam int LAT = 4;
	localparam logic [7:0] SCALE_RESET = 8'd100;

	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_ENTER = 2'd1,
		EV_STAY = 2'd2,
		EV_EXIT = 2'd3
	} pair_event_t;

	typedef enum logic [1:0] {
		TEST_RR = 2'd0,
		TEST_CC = 2'd1,
		TEST_RC = 2'd2
	} test_kind_t;
endpackage

// ===== rtl/cpet_ram.sv =====
module cpet_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/cpet_geom.sv =====
module cpet_geom import cpet_pkg::*; (
	input  logic               clk,
	input  logic [7:0]         scale,
	input  logic               first_kind,
	input  logic               second_kind,
	input  logic signed [23:0] first_x,
	input  logic signed [23:0] first_y,
	input  logic [15:0]        first_w,
	input  logic [15:0]        first_h,
	input  logic signed [23:0] second_x,
	input  logic signed [23:0] second_y,
	input  logic [15:0]        second_w,
	input  logic [15:0]        second_h,
	output logic               hit
);
	// Stage 1: scale sizes, form doubled centers, select rect/circle roles.
	test_kind_t         kind_s1;
	logic [23:0]        aw_s1, ah_s1, bw_s1, bh_s1;
	logic signed [25:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic signed [25:0] rx, ry, cx, cy;

	always_ff @(posedge clk) begin
		kind_s1 <= (!first_kind && !second_kind) ? TEST_RR :
			((first_kind && second_kind) ? TEST_CC : TEST_RC);
		aw_s1 <= first_w * scale;
		ah_s1 <= first_h * scale;
		bw_s1 <= second_w * scale;
		bh_s1 <= second_h * scale;
		ax_s1 <= 26'(first_x) <<< 1;
		ay_s1 <= 26'(first_y) <<< 1;
		bx_s1 <= 26'(second_x) <<< 1;
		by_s1 <= 26'(second_y) <<< 1;
		if (first_kind) begin
			rx <= 26'(second_x) <<< 1;
			ry <= 26'(second_y) <<< 1;
			cx <= 26'(first_x) <<< 1;
			cy <= 26'(first_y) <<< 1;
		end else begin
			rx <= 26'(first_x) <<< 1;
			ry <= 26'(first_y) <<< 1;
			cx <= 26'(second_x) <<< 1;
			cy <= 26'(second_y) <<< 1;
		end
	end

	logic rsel_a;
	always_ff @(posedge clk) begin
		rsel_a <= !first_kind;
	end

	// Stage 2: distances. All values fit in 28 bits signed.
	logic signed [27:0] dx, dy, rlo_x, rhi_x, rlo_y, rhi_y, px, py, ex, ey;
	logic [24:0]        sw, sh;
	logic [23:0]        rwv, rhv, cdv;
	logic [26:0]        mx_s2, my_s2;
	logic [24:0]        sw_s2, sh_s2;
	test_kind_t         kind_s2;

	always_comb begin
		rwv = rsel_a ? aw_s1 : bw_s1;
		rhv = rsel_a ? ah_s1 : bh_s1;
		cdv = rsel_a ? bw_s1 : aw_s1;
		dx = 28'(ax_s1) - 28'(bx_s1);
		dy = 28'(ay_s1) - 28'(by_s1);
		rlo_x = 28'(rx) - 28'(rwv);
		rhi_x = 28'(rx) + 28'(rwv);
		rlo_y = 28'(ry) - 28'(rhv);
		rhi_y = 28'(ry) + 28'(rhv);
		px = 28'(cx);
		if (px > rhi_x) px = rhi_x;
		if (px < rlo_x) px = rlo_x;
		py = 28'(cy);
		if (py > rhi_y) py = rhi_y;
		if (py < rlo_y) py = rlo_y;
		ex = 28'(cx) - px;
		ey = 28'(cy) - py;
		if (kind_s1 == TEST_RC) begin
			dx = ex;
			dy = ey;
		end
		sw = (kind_s1 == TEST_RC) ? 25'(cdv) : 25'(aw_s1) + 25'(bw_s1);
		sh = 25'(ah_s1) + 25'(bh_s1);
	end

	always_ff @(posedge clk) begin
		mx_s2 <= dx[27] ? 27'(-dx) : 27'(dx);
		my_s2 <= dy[27] ? 27'(-dy) : 27'(dy);
		sw_s2 <= sw;
		sh_s2 <= sh;
		kind_s2 <= kind_s1;
	end

	// Stage 3: squares; rect-rect compares directly.
	logic [53:0] sqx_s3, sqy_s3;
	logic [49:0] sqr_s3;
	logic        rr_s3;
	test_kind_t  kind_s3;

	always_ff @(posedge clk) begin
		sqx_s3 <= mx_s2 * mx_s2;
		sqy_s3 <= my_s2 * my_s2;
		sqr_s3 <= sw_s2 * sw_s2;
		rr_s3 <= (27'(sw_s2) > mx_s2) && (27'(sh_s2) > my_s2);
		kind_s3 <= kind_s2;
	end

	always_ff @(posedge clk) begin
		if (kind_s3 == TEST_RR) begin
			hit <= rr_s3;
		end else begin
			hit <= (55'(sqx_s3) + 55'(sqy_s3)) <= 55'(sqr_s3);
		end
	end
endmodule

// ===== rtl/collision_pair_event_tracker_unit.sv =====
// Collision pair tracker: one pair may be started every cycle while busy is low.
// Each start yields exactly one result, marked by done for one cycle; the
// receiver cannot stall it. The result passes through the scaling, distance,
// squaring and compare stages. Pair state sits in a 4096 x 1 RAM read at start
// and written when the result forms; a repeated pair is forwarded from the
// write stage. Pair bits are cleared by a sweep over all 4096 entries after
// reset, during which busy is high; size_scale writes are taken at any time.
module collision_pair_event_tracker_unit import cpet_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data,
	input  logic [5:0]         first_id,
	input  logic [5:0]         second_id,
	input  logic               first_kind,
	input  logic               second_kind,
	input  logic signed [23:0] first_x,
	input  logic signed [23:0] first_y,
	input  logic [15:0]        first_w,
	input  logic [15:0]        first_h,
	input  logic signed [23:0] second_x,
	input  logic signed [23:0] second_y,
	input  logic [15:0]        second_w,
	input  logic [15:0]        second_h,
	output logic               done,
	output logic [1:0]         pair_event,
	output logic               overlapping
);
	logic [7:0]       scale_q;
	logic             clr_q;
	logic [IDX_W-1:0] clr_idx_q;
	logic             hit;
	logic [LAT-1:0]   vld_q;
	logic [IDX_W-1:0] idx_q [LAT];
	logic             acc;
	logic [IDX_W-1:0] idx_in;
	logic             rd_bit;
	logic             prev_bit;
	logic             we;
	logic [IDX_W-1:0] waddr;
	logic             wdata;

	assign cfg_ready = 1'b1;
	assign busy = clr_q;
	assign acc = start && !busy;
	assign idx_in = {ID_W'(first_id), ID_W'(second_id)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
			clr_q <= 1'b1;
			clr_idx_q <= '0;
			vld_q <= '0;
		end else begin
			if (cfg_valid) begin
				scale_q <= cfg_data;
			end
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (&clr_idx_q) begin
					clr_q <= 1'b0;
				end
			end
			vld_q <= {vld_q[LAT-2:0], acc};
		end
	end

	always_ff @(posedge clk) begin
		idx_q[0] <= idx_in;
		for (int i = 1; i < LAT; i++) begin
			idx_q[i] <= idx_q[i-1];
		end
	end

	// Pair bit is read at start; updates landing in the read window are forwarded.
	cpet_ram #(.WIDTH(1), .DEPTH(PAIRS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(idx_in), .rdata(rd_bit)
	);

	logic           bit_q [LAT];
	logic           bitv_q [LAT];

	always_ff @(posedge clk) begin
		// Stage 0 takes the write of this very cycle if same pair; RAM data goes to ram_bit_q[1].
		if (we && waddr == idx_in) begin
			bitv_q[0] <= 1'b1;
			bit_q[0] <= wdata;
		end else begin
			bitv_q[0] <= 1'b0;
			bit_q[0] <= 1'b0;
		end
		for (int i = 1; i < LAT; i++) begin
			if (we && waddr == idx_q[i-1]) begin
				bitv_q[i] <= 1'b1;
				bit_q[i] <= wdata;
			end else begin
				bitv_q[i] <= bitv_q[i-1];
				bit_q[i] <= bit_q[i-1];
			end
		end
	end

	logic ram_bit_q [1:LAT-1];
	always_ff @(posedge clk) begin
		ram_bit_q[1] <= (bitv_q[0]) ? bit_q[0] : rd_bit;
		for (int i = 2; i < LAT; i++) begin
			ram_bit_q[i] <= ram_bit_q[i-1];
		end
	end

	assign prev_bit = bitv_q[LAT-1] ? bit_q[LAT-1] : ram_bit_q[LAT-1];

	cpet_geom u_geom (
		.clk(clk), .scale(scale_q),
		.first_kind(first_kind), .second_kind(second_kind),
		.first_x(first_x), .first_y(first_y), .first_w(first_w), .first_h(first_h),
		.second_x(second_x), .second_y(second_y), .second_w(second_w),
		.second_h(second_h), .hit(hit)
	);

	assign we = clr_q || vld_q[LAT-1];
	assign waddr = clr_q ? clr_idx_q : idx_q[LAT-1];
	assign wdata = clr_q ? 1'b0 : hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		overlapping <= hit;
		if (hit) begin
			pair_event <= prev_bit ? EV_STAY : EV_ENTER;
		end else begin
			pair_event <= prev_bit ? EV_EXIT : EV_NONE;
		end
	end
endmodule
